FILE: sv/arpmon_pkg.sv
// Shared types and constants for the ARP reply monitor.
`timescale 1ns / 1ps
`default_nettype none
package arpmon_pkg;

    localparam int NEIGHBOR_ENTRIES_DEFAULT = 64;

    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_STATS = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [1:0] EV_REPLY   = 2'd0;
    localparam logic [1:0] EV_SPOOF   = 2'd1;
    localparam logic [1:0] EV_TIMEOUT = 2'd2;
    localparam logic [1:0] EV_STATS   = 2'd3;

    localparam logic [1:0] REG_ROLE    = 2'd0;
    localparam logic [1:0] REG_TIMEOUT = 2'd1;

    localparam logic        ROLE_REQUESTER = 1'b0;
    localparam logic        ROLE_RESPONDER = 1'b1;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;

    localparam logic [7:0]  ETHERTYPE_HI = 8'h08;
    localparam logic [7:0]  ETHERTYPE_LO = 8'h06;
    localparam logic [15:0] OP_REQUEST   = 16'd1;
    localparam logic [15:0] OP_REPLY     = 16'd2;
    localparam logic [5:0]  CAP_BYTES    = 6'd32;
    localparam logic [5:0]  MIN_FRAME    = 6'd22;
    localparam logic [5:0]  POS_TYPE_HI  = 6'd12;
    localparam logic [5:0]  POS_TYPE_LO  = 6'd13;
    localparam logic [5:0]  POS_OP_HI    = 6'd20;
    localparam logic [5:0]  POS_OP_LO    = 6'd21;
    localparam logic [5:0]  POS_MAC_LAST = 6'd27;
    localparam logic [5:0]  POS_IP_LAST  = 6'd31;

    localparam logic [31:0] UNKNOWN_LATENCY = 32'd5;
    localparam logic [6:0]  PERCENT         = 7'd100;
    localparam logic [31:0] MIN_RESET       = 32'hFFFF_FFFF;

    localparam int DIV_W = 40;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  data_byte;
        logic        end_of_frame;
        logic [63:0] timestamp;
    } item_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic        last_of_run;
        logic [47:0] peer_mac;
        logic [31:0] latency;
        logic [31:0] reply_total;
        logic [31:0] timeout_total;
        logic [31:0] spoof_total;
        logic [6:0]  loss_percent;
        logic [31:0] mean_latency;
        logic [31:0] worst_latency;
        logic [31:0] best_latency;
    } result_t;

    typedef enum logic [2:0] {
        JOB_REPLY,
        JOB_REQUEST,
        JOB_TICK,
        JOB_STATS,
        JOB_CLEAR
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [63:0] ts;
        logic [47:0] mac;
        logic [31:0] ip;
    } job_t;

endpackage
`default_nettype wire

FILE: sv/arpmon_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module arpmon_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

FILE: sv/arpmon_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module arpmon_div
    import arpmon_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DIV_W-1:0] dividend,
    input  wire logic [32:0]      divisor,
    output logic                  done,
    output logic      [DIV_W-1:0] quotient
);
    localparam int CW = $clog2(DIV_W + 1);

    logic [CW-1:0]    count_reg, count_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W-1:0] dq_reg, dq_next;
    logic [32:0]      rem_reg, rem_next;
    logic [32:0]      dvs_reg, dvs_next;
    logic [33:0]      trial;
    logic [33:0]      diff;

    assign trial = {rem_reg, dq_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = CW'(DIV_W);
            dq_next    = dividend;
            rem_next   = '0;
            dvs_next   = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[33])
            begin
                rem_next = diff[32:0];
                dq_next  = {dq_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[32:0];
                dq_next  = {dq_reg[DIV_W-2:0], 1'b0};
            end
            count_next = count_reg - 1'b1;
            if (count_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;
endmodule
`default_nettype wire

FILE: sv/arpmon_front.sv
// Front end: captures frame bytes, classifies frames and commands, queues jobs.
`timescale 1ns / 1ps
`default_nettype none
module arpmon_front
    import arpmon_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    output logic       full,
    input  wire item_t item,
    input  wire logic  role,
    output logic       job_valid,
    output job_t       job,
    input  wire logic  job_pop
);
    logic [5:0]  pos_reg, pos_next;
    logic [7:0]  type_hi_reg, type_hi_next;
    logic [7:0]  type_lo_reg, type_lo_next;
    logic [15:0] op_reg, op_next;
    logic [47:0] mac_reg, mac_next;
    logic [31:0] ip_reg, ip_next;

    job_t        q_reg [2];
    logic        wptr_reg, rptr_reg;
    logic [1:0]  cnt_reg;

    logic        accept;
    logic        do_push;
    logic        do_pop;
    job_t        new_job;
    logic [2:0]  mac_sel;
    logic [1:0]  ip_sel;
    logic        is_arp;

    assign full   = (cnt_reg == 2'd2);
    assign accept = push && !full;
    assign do_pop = job_pop && (cnt_reg != 2'd0);

    always_comb
    begin
        pos_next     = pos_reg;
        type_hi_next = type_hi_reg;
        type_lo_next = type_lo_reg;
        op_next      = op_reg;
        mac_next     = mac_reg;
        ip_next      = ip_reg;
        mac_sel      = 3'(POS_MAC_LAST - pos_reg);
        ip_sel       = 2'(POS_IP_LAST - pos_reg);
        if (accept && item.cmd == CMD_BYTE && pos_reg < CAP_BYTES)
        begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg == POS_TYPE_HI)
            begin
                type_hi_next = item.data_byte;
            end
            if (pos_reg == POS_TYPE_LO)
            begin
                type_lo_next = item.data_byte;
            end
            if (pos_reg == POS_OP_HI)
            begin
                op_next[15:8] = item.data_byte;
            end
            if (pos_reg == POS_OP_LO)
            begin
                op_next[7:0] = item.data_byte;
            end
            if (pos_reg > POS_OP_LO && pos_reg <= POS_MAC_LAST)
            begin
                mac_next[mac_sel*8 +: 8] = item.data_byte;
            end
            if (pos_reg > POS_MAC_LAST)
            begin
                ip_next[ip_sel*8 +: 8] = item.data_byte;
            end
        end

        is_arp = (pos_next >= MIN_FRAME) && (type_hi_next == ETHERTYPE_HI)
                 && (type_lo_next == ETHERTYPE_LO);

        new_job.kind = JOB_CLEAR;
        new_job.ts   = item.timestamp;
        new_job.mac  = mac_next;
        new_job.ip   = ip_next;
        do_push      = 1'b0;
        if (accept)
        begin
            unique case (item.cmd)
                CMD_BYTE:
                begin
                    if (item.end_of_frame)
                    begin
                        if (is_arp && op_next == OP_REPLY && role == ROLE_REQUESTER)
                        begin
                            new_job.kind = JOB_REPLY;
                            do_push      = 1'b1;
                        end
                        else if (is_arp && op_next == OP_REQUEST
                                 && role == ROLE_RESPONDER)
                        begin
                            new_job.kind = JOB_REQUEST;
                            do_push      = 1'b1;
                        end
                    end
                end
                CMD_TICK:
                begin
                    new_job.kind = JOB_TICK;
                    do_push      = 1'b1;
                end
                CMD_STATS:
                begin
                    new_job.kind = JOB_STATS;
                    do_push      = 1'b1;
                end
                default:
                begin
                    new_job.kind = JOB_CLEAR;
                    do_push      = 1'b1;
                end
            endcase
            if (item.cmd == CMD_CLEAR || (item.cmd == CMD_BYTE && item.end_of_frame))
            begin
                pos_next     = '0;
                type_hi_next = '0;
                type_lo_next = '0;
                op_next      = '0;
                mac_next     = '0;
                ip_next      = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            type_hi_reg <= '0;
            type_lo_reg <= '0;
            op_reg      <= '0;
            mac_reg     <= '0;
            ip_reg      <= '0;
            wptr_reg    <= 1'b0;
            rptr_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            pos_reg     <= pos_next;
            type_hi_reg <= type_hi_next;
            type_lo_reg <= type_lo_next;
            op_reg      <= op_next;
            mac_reg     <= mac_next;
            ip_reg      <= ip_next;
            if (do_push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wptr_reg] <= new_job;
        end
    end

    assign job_valid = (cnt_reg != 2'd0);
    assign job       = q_reg[rptr_reg];
endmodule
`default_nettype wire

FILE: sv/arpmon_back.sv
// Back end: executes queued jobs, walks the neighbor table, queues results.
`timescale 1ns / 1ps
`default_nettype none
module arpmon_back
    import arpmon_pkg::*;
#(
    parameter int NEIGHBOR_ENTRIES = NEIGHBOR_ENTRIES_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        job_valid,
    input  wire job_t        job,
    output logic             job_pop,
    input  wire logic [15:0] timeout_ms,
    output logic             empty,
    input  wire logic        pop,
    output result_t          result
);
    localparam int AW = $clog2(NEIGHBOR_ENTRIES);
    localparam int FW = $clog2(NEIGHBOR_ENTRIES + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_LOSS,
        ST_LOSS_WAIT,
        ST_MEAN,
        ST_MEAN_WAIT,
        ST_FLUSH
    } state_t;

    state_t      state_reg, state_next;
    logic [63:0] rt_reg, rt_next;
    logic        await_reg, await_next;
    logic [31:0] reply_cnt_reg, reply_cnt_next;
    logic [31:0] tmo_cnt_reg, tmo_cnt_next;
    logic [31:0] spoof_cnt_reg, spoof_cnt_next;
    logic [31:0] sum_reg, sum_next;
    logic [31:0] samples_reg, samples_next;
    logic [31:0] max_reg, max_next;
    logic [31:0] min_reg, min_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] walk_reg, walk_next;
    logic [FW-1:0] last_reg, last_next;
    logic [47:0] mac_reg, mac_next;
    logic [31:0] ip_reg, ip_next;
    logic [6:0]  loss_reg, loss_next;
    result_t     pend_reg, pend_next;

    result_t     oq_reg [2];
    logic        owptr_reg, orptr_reg;
    logic [1:0]  ocnt_reg;
    logic        opush;
    logic        opop;
    result_t     opush_data;
    logic        ospace;

    logic        ram_we;
    logic [79:0] ram_rd;
    logic        div_start;
    logic [DIV_W-1:0] div_dividend;
    logic [32:0] div_divisor;
    logic        div_done;
    logic [DIV_W-1:0] div_q;

    logic [63:0] elapsed;
    logic [31:0] lat;
    logic [32:0] total;
    logic [38:0] tmo_x100;
    result_t     blank;

    arpmon_ram #(
        .WIDTH (80),
        .DEPTH (NEIGHBOR_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data ({job.mac, job.ip}),
        .rd_addr (walk_reg[AW-1:0]),
        .rd_data (ram_rd)
    );

    arpmon_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign ospace   = (ocnt_reg != 2'd2) || pop;
    assign elapsed  = job.ts - rt_reg;
    assign total    = {1'b0, reply_cnt_reg} + {1'b0, tmo_cnt_reg};
    assign tmo_x100 = tmo_cnt_reg * PERCENT;

    always_comb
    begin
        state_next     = state_reg;
        rt_next        = rt_reg;
        await_next     = await_reg;
        reply_cnt_next = reply_cnt_reg;
        tmo_cnt_next   = tmo_cnt_reg;
        spoof_cnt_next = spoof_cnt_reg;
        sum_next       = sum_reg;
        samples_next   = samples_reg;
        max_next       = max_reg;
        min_next       = min_reg;
        fill_next      = fill_reg;
        walk_next      = walk_reg;
        last_next      = last_reg;
        mac_next       = mac_reg;
        ip_next        = ip_reg;
        loss_next      = loss_reg;
        pend_next      = pend_reg;
        job_pop        = 1'b0;
        ram_we         = 1'b0;
        div_start      = 1'b0;
        div_dividend   = {1'b0, tmo_x100};
        div_divisor    = total;
        opush          = 1'b0;
        opush_data     = pend_reg;
        blank          = '0;

        lat = UNKNOWN_LATENCY;
        if (rt_reg != 64'd0 && job.ts != 64'd0)
        begin
            lat = (job.ts > rt_reg) ? elapsed[31:0] : 32'd0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop = 1'b1;
                    unique case (job.kind)
                        JOB_REPLY:
                        begin
                            pend_next            = blank;
                            pend_next.event_kind = EV_REPLY;
                            pend_next.peer_mac   = job.mac;
                            pend_next.latency    = lat;
                            reply_cnt_next = reply_cnt_reg + 1'b1;
                            sum_next       = sum_reg + lat;
                            samples_next   = samples_reg + 1'b1;
                            if (lat > max_reg)
                            begin
                                max_next = lat;
                            end
                            if (lat < min_reg)
                            begin
                                min_next = lat;
                            end
                            await_next = 1'b0;
                            state_next = ST_FLUSH;
                            if (fill_reg < FW'(NEIGHBOR_ENTRIES))
                            begin
                                ram_we    = 1'b1;
                                fill_next = fill_reg + 1'b1;
                                last_next = fill_reg;
                                walk_next = '0;
                                mac_next  = job.mac;
                                ip_next   = job.ip;
                                if (fill_reg != '0)
                                begin
                                    state_next = ST_WALK_RD;
                                end
                            end
                        end
                        JOB_REQUEST:
                        begin
                            if (job.ts != 64'd0)
                            begin
                                rt_next = job.ts;
                            end
                            await_next = 1'b1;
                        end
                        JOB_TICK:
                        begin
                            if (await_reg && rt_reg != 64'd0 && job.ts > rt_reg
                                && elapsed > {48'd0, timeout_ms})
                            begin
                                pend_next            = blank;
                                pend_next.event_kind = EV_TIMEOUT;
                                tmo_cnt_next = tmo_cnt_reg + 1'b1;
                                await_next   = 1'b0;
                                state_next   = ST_FLUSH;
                            end
                        end
                        JOB_STATS:
                        begin
                            state_next = ST_LOSS;
                        end
                        JOB_CLEAR:
                        begin
                            await_next     = 1'b0;
                            reply_cnt_next = '0;
                            tmo_cnt_next   = '0;
                            spoof_cnt_next = '0;
                            sum_next       = '0;
                            samples_next   = '0;
                            max_next       = '0;
                            min_next       = MIN_RESET;
                            fill_next      = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK_RD:
            begin
                state_next = ST_WALK_CMP;
            end
            ST_WALK_CMP:
            begin
                if (ram_rd[31:0] == ip_reg && ram_rd[79:32] != mac_reg)
                begin
                    if (ospace)
                    begin
                        opush                    = 1'b1;
                        opush_data.last_of_run   = 1'b0;
                        pend_next                = blank;
                        pend_next.event_kind     = EV_SPOOF;
                        spoof_cnt_next           = spoof_cnt_reg + 1'b1;
                        walk_next                = walk_reg + 1'b1;
                        state_next = (walk_reg + 1'b1 == last_reg) ? ST_FLUSH : ST_WALK_RD;
                    end
                end
                else
                begin
                    walk_next  = walk_reg + 1'b1;
                    state_next = (walk_reg + 1'b1 == last_reg) ? ST_FLUSH : ST_WALK_RD;
                end
            end
            ST_LOSS:
            begin
                loss_next = '0;
                if (total != 33'd0)
                begin
                    div_start  = 1'b1;
                    state_next = ST_LOSS_WAIT;
                end
                else
                begin
                    state_next = ST_MEAN;
                end
            end
            ST_LOSS_WAIT:
            begin
                if (div_done)
                begin
                    loss_next  = div_q[6:0];
                    state_next = ST_MEAN;
                end
            end
            ST_MEAN:
            begin
                pend_next               = blank;
                pend_next.event_kind    = EV_STATS;
                pend_next.reply_total   = reply_cnt_reg;
                pend_next.timeout_total = tmo_cnt_reg;
                pend_next.spoof_total   = spoof_cnt_reg;
                pend_next.loss_percent  = loss_reg;
                pend_next.worst_latency = max_reg;
                pend_next.best_latency  = (min_reg == MIN_RESET) ? 32'd0 : min_reg;
                div_dividend = {8'd0, sum_reg};
                div_divisor  = {1'b0, samples_reg};
                if (samples_reg != 32'd0)
                begin
                    div_start  = 1'b1;
                    state_next = ST_MEAN_WAIT;
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    pend_next.mean_latency = div_q[31:0];
                    state_next             = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (ospace)
                begin
                    opush                  = 1'b1;
                    opush_data.last_of_run = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign opop = pop && (ocnt_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rt_reg        <= '0;
            await_reg     <= 1'b0;
            reply_cnt_reg <= '0;
            tmo_cnt_reg   <= '0;
            spoof_cnt_reg <= '0;
            sum_reg       <= '0;
            samples_reg   <= '0;
            max_reg       <= '0;
            min_reg       <= MIN_RESET;
            fill_reg      <= '0;
            walk_reg      <= '0;
            last_reg      <= '0;
            mac_reg       <= '0;
            ip_reg        <= '0;
            loss_reg      <= '0;
            pend_reg      <= '0;
            owptr_reg     <= 1'b0;
            orptr_reg     <= 1'b0;
            ocnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rt_reg        <= rt_next;
            await_reg     <= await_next;
            reply_cnt_reg <= reply_cnt_next;
            tmo_cnt_reg   <= tmo_cnt_next;
            spoof_cnt_reg <= spoof_cnt_next;
            sum_reg       <= sum_next;
            samples_reg   <= samples_next;
            max_reg       <= max_next;
            min_reg       <= min_next;
            fill_reg      <= fill_next;
            walk_reg      <= walk_next;
            last_reg      <= last_next;
            mac_reg       <= mac_next;
            ip_reg        <= ip_next;
            loss_reg      <= loss_next;
            pend_reg      <= pend_next;
            if (opush)
            begin
                owptr_reg <= ~owptr_reg;
            end
            if (opop)
            begin
                orptr_reg <= ~orptr_reg;
            end
            ocnt_reg <= ocnt_reg + 2'(opush) - 2'(opop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (opush)
        begin
            oq_reg[owptr_reg] <= opush_data;
        end
    end

    assign empty  = (ocnt_reg == 2'd0);
    assign result = oq_reg[orptr_reg];
endmodule
`default_nettype wire

FILE: sv/arp_reply_monitor.sv
// Top level of the ARP reply monitor: configuration registers, front and back ends.
//
// Input queue: drive item and push; a request is taken at a clock edge where push
// is high and full is low. Commands are frame bytes, tick, statistics read and clear.
// Result queue: while empty is low the oldest result sits on result; pop takes it.
// The last result caused by one request has last_of_run set.
// Configuration: cfg_valid/cfg_ready write cfg_data to register cfg_index
// (0 role, 1 timeout_ms); cfg_ready is always high. Write only while idle.
// Frame bytes are taken whenever full is low. A frame's judgment, a tick or a
// clear is handled in the back end's idle state, plus a flush state for a result; a
// reply with the table holding F entries walks it with a read and a compare state per
// entry. Statistics run up to two divisions, loss then mean, in the shared divider.
// A two-entry job queue lets bytes keep flowing while the back end walks the table;
// full rises only when that queue is full. A two-entry result queue decouples pop.
// Reset clears counters, the frame in progress and both queues; role resets to
// requester and timeout_ms to 1000. The neighbor table needs no clearing pass.
// When pop stays low, the back end holds in place and full eventually rises.
`timescale 1ns / 1ps
`default_nettype none
module arp_reply_monitor
    import arpmon_pkg::*;
#(
    parameter int NEIGHBOR_ENTRIES = NEIGHBOR_ENTRIES_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire item_t       item,
    output logic             empty,
    input  wire logic        pop,
    output result_t          result,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    logic        role_reg;
    logic [15:0] timeout_reg;
    logic        job_valid;
    logic        job_pop;
    job_t        job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            role_reg    <= ROLE_REQUESTER;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_ROLE)
            begin
                role_reg <= cfg_data[0];
            end
            if (cfg_index == REG_TIMEOUT)
            begin
                timeout_reg <= cfg_data;
            end
        end
    end

    arpmon_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .role      (role_reg),
        .job_valid (job_valid),
        .job       (job),
        .job_pop   (job_pop)
    );

    arpmon_back #(
        .NEIGHBOR_ENTRIES (NEIGHBOR_ENTRIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job        (job),
        .job_pop    (job_pop),
        .timeout_ms (timeout_reg),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );
endmodule
`default_nettype wire
